[hdl/hbd_pkg.sv]
// hbd_pkg: constants, lobe tables and types for the hessian box determinant
`timescale 1ns / 1ps

package hbd_pkg;

    localparam int FILTER_SIZE  = 9;
    localparam int WIN          = FILTER_SIZE + 1;
    localparam int HALF_FILTER  = FILTER_SIZE / 2;
    localparam int SLOT_BITS    = $clog2(FILTER_SIZE);
    localparam int CFG_BITS     = 10;
    localparam int DET_BITS     = 28;
    localparam int STORED_BITS  = 16;
    localparam int COORD_BITS   = 9;
    localparam int DXY_BITS     = DET_BITS + 1;
    localparam int MAX_COLS_DEF = 512;
    localparam int MAX_ROWS_DEF = 512;
    localparam int VALUE_BITS_DEF = 25;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(320);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(240);

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [3:0] r0;
        logic [3:0] c0;
        logic [3:0] r1;
        logic [3:0] c1;
        logic       neg;
    } lobe_t;

    localparam lobe_t LOBES_XX [3] = '{
        '{4'd2, 4'd0, 4'd7, 4'd3, 1'b0},
        '{4'd2, 4'd3, 4'd7, 4'd6, 1'b1},
        '{4'd2, 4'd6, 4'd7, 4'd9, 1'b0}
    };
    localparam lobe_t LOBES_YY [3] = '{
        '{4'd0, 4'd2, 4'd3, 4'd7, 1'b0},
        '{4'd3, 4'd2, 4'd6, 4'd7, 1'b1},
        '{4'd6, 4'd2, 4'd9, 4'd7, 1'b0}
    };
    localparam lobe_t LOBES_XY [4] = '{
        '{4'd1, 4'd1, 4'd4, 4'd4, 1'b0},
        '{4'd1, 4'd5, 4'd4, 4'd8, 1'b1},
        '{4'd5, 4'd1, 4'd8, 4'd4, 1'b1},
        '{4'd5, 4'd5, 4'd8, 4'd8, 1'b0}
    };

endpackage

[hdl/hessian_box_determinant.sv]
// hessian_box_determinant: 9x9 fast-hessian determinant over an integral-image stream
`timescale 1ns / 1ps
//
// Input channel s_*: one integral-image value per item, raster order, image_width+1
// values per row and image_height+1 rows per frame; s_frame_start marks position (0,0).
// Output channel m_*: one determinant item for every input item whose position
// completes a 10x10 window (row and column both at least 9), none otherwise.
// Configuration: cfg_wr_en writes cfg_data into the register cfg_index selects
// (0 image width, 1 image height); write only while the block is idle.
// Throughput: one item per cycle unless the receiver stalls. The nine previous rows
// live in one line memory read and written at the item's column in its accept
// cycle; the window shifts one column per item.
// Pipeline: an accepted item passes the memory read, window shift, lobe sums and
// products, then the output register.
// Reset clears counters, pipeline valids and the output valid; widths go back
// to 320 x 240. The line memory is not cleared.
// When the receiver stalls with a result pending, the whole pipeline holds and
// s_ready falls; it rises again in the cycle the result is taken.

module hessian_box_determinant #(
    parameter int MAX_COLS   = hbd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = hbd_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS = hbd_pkg::VALUE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [hbd_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [VALUE_BITS-1:0]              s_integral_value,
    input  logic                               s_frame_start,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [hbd_pkg::DET_BITS-1:0] m_det_value,
    output logic [hbd_pkg::STORED_BITS-1:0]    m_det_stored,
    output logic [hbd_pkg::COORD_BITS-1:0]     m_out_row,
    output logic [hbd_pkg::COORD_BITS-1:0]     m_out_col,
    output logic                               m_frame_last
);

    localparam int FS      = hbd_pkg::FILTER_SIZE;
    localparam int WIN     = hbd_pkg::WIN;
    localparam int SB      = hbd_pkg::SLOT_BITS;
    localparam int CB      = hbd_pkg::CFG_BITS;
    localparam int DB      = hbd_pkg::DET_BITS;
    localparam int XB      = hbd_pkg::DXY_BITS;
    localparam int PB      = hbd_pkg::COORD_BITS;
    localparam int DEPTH   = MAX_COLS + 1;
    localparam int COLB    = $clog2(MAX_COLS + 1);
    localparam int ROWB    = $clog2(MAX_ROWS + 1);
    localparam int ADDRB   = $clog2(DEPTH);
    localparam int DIMB    = (COLB > ROWB ? COLB : ROWB) + 1;
    localparam int LB      = VALUE_BITS + 5;

    localparam logic [DIMB-1:0] MAXC = DIMB'(MAX_COLS);
    localparam logic [DIMB-1:0] MAXR = DIMB'(MAX_ROWS);
    localparam logic [SB-1:0]   LAST_SLOT = SB'(FS - 1);

    typedef logic [VALUE_BITS-1:0] val_t;

    // configuration
    logic [CB-1:0] width_reg, height_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= hbd_pkg::WIDTH_RESET;
            height_reg <= hbd_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == hbd_pkg::REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data;
            end else begin
                height_reg <= cfg_data;
            end
        end
    end

    logic [DIMB-1:0] w_lim, h_lim;
    always_comb begin
        w_lim = (DIMB'(width_reg) > MAXC) ? MAXC : DIMB'(width_reg);
        h_lim = (DIMB'(height_reg) > MAXR) ? MAXR : DIMB'(height_reg);
    end

    // pipeline control
    logic m_valid_reg;
    logic adv, accept;
    assign adv    = !(m_valid_reg && !m_ready);
    assign s_ready = adv;
    assign accept = s_valid && adv;

    // position counters
    logic [COLB-1:0] col_count_reg, col_count_next;
    logic [ROWB-1:0] row_count_reg, row_count_next;
    logic [SB-1:0]   row_slot_reg, row_slot_next;
    logic [COLB-1:0] cur_col;
    logic [ROWB-1:0] cur_row;
    logic [SB-1:0]   cur_slot;

    always_comb begin
        cur_col  = s_frame_start ? '0 : col_count_reg;
        cur_row  = s_frame_start ? '0 : row_count_reg;
        cur_slot = s_frame_start ? '0 : row_slot_reg;
        col_count_next = cur_col;
        row_count_next = cur_row;
        row_slot_next  = cur_slot;
        if (DIMB'(cur_col) >= w_lim) begin
            col_count_next = '0;
            if (DIMB'(cur_row) >= h_lim) begin
                row_count_next = '0;
                row_slot_next  = '0;
            end else begin
                row_count_next = cur_row + 1'b1;
                row_slot_next  = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;
            end
        end else begin
            col_count_next = cur_col + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            row_slot_reg  <= '0;
        end else if (accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            row_slot_reg  <= row_slot_next;
        end
    end

    // line memory: one entry per column, one slot per stored row
    val_t line_mem [DEPTH][FS];
    val_t rdata_reg [FS];
    logic [ADDRB-1:0] mem_addr;
    assign mem_addr = ADDRB'(cur_col);

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_mem[mem_addr][cur_slot] <= s_integral_value;
            rdata_reg <= line_mem[mem_addr];
        end
    end

    // stage 1: item waiting to enter the window
    logic            s1_valid_reg;
    val_t            s1_value_reg;
    logic [SB-1:0]   s1_slot_reg;
    logic            s1_hit_reg;
    logic            s1_last_reg;
    logic [PB-1:0]   s1_row_reg, s1_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_value_reg <= s_integral_value;
            s1_slot_reg  <= cur_slot;
            s1_hit_reg   <= (cur_row >= ROWB'(FS)) && (cur_col >= COLB'(FS));
            s1_last_reg  <= (DIMB'(cur_row) == h_lim) && (DIMB'(cur_col) == w_lim);
            s1_row_reg   <= PB'(cur_row - ROWB'(FS - hbd_pkg::HALF_FILTER));
            s1_col_reg   <= PB'(cur_col - COLB'(FS - hbd_pkg::HALF_FILTER));
        end
    end

    // stage 2: window registers
    val_t window_reg [WIN][WIN];
    logic [SB-1:0] slot_sel [FS];

    always_comb begin
        for (int y = 0; y < FS; y++) begin
            logic [SB:0] s;
            s = {1'b0, s1_slot_reg} + (SB+1)'(y);
            slot_sel[y] = (s >= (SB+1)'(FS)) ? SB'(s - (SB+1)'(FS)) : SB'(s);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            for (int y = 0; y < WIN; y++) begin
                for (int x = 0; x < WIN - 1; x++) begin
                    window_reg[y][x] <= window_reg[y][x+1];
                end
            end
            for (int y = 0; y < FS; y++) begin
                window_reg[y][WIN-1] <= rdata_reg[slot_sel[y]];
            end
            window_reg[WIN-1][WIN-1] <= s1_value_reg;
        end
    end

    logic          s2_valid_reg;
    logic          s2_last_reg;
    logic [PB-1:0] s2_row_reg, s2_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg && s1_hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_last_reg <= s1_last_reg;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
        end
    end

    // lobe sums
    function automatic logic signed [LB-1:0] box_sum(hbd_pkg::lobe_t l,
                                                      logic signed [LB-1:0] a,
                                                      logic signed [LB-1:0] b,
                                                      logic signed [LB-1:0] c,
                                                      logic signed [LB-1:0] d);
        logic signed [LB-1:0] s;
        s = a + b - c - d;
        return l.neg ? -s : s;
    endfunction

    logic signed [LB-1:0] dxx, dyy, dxy;

    always_comb begin
        dxx = '0;
        dyy = '0;
        dxy = '0;
        for (int i = 0; i < 3; i++) begin
            dxx = dxx + box_sum(hbd_pkg::LOBES_XX[i],
                LB'(window_reg[hbd_pkg::LOBES_XX[i].r0][hbd_pkg::LOBES_XX[i].c0]),
                LB'(window_reg[hbd_pkg::LOBES_XX[i].r1][hbd_pkg::LOBES_XX[i].c1]),
                LB'(window_reg[hbd_pkg::LOBES_XX[i].r1][hbd_pkg::LOBES_XX[i].c0]),
                LB'(window_reg[hbd_pkg::LOBES_XX[i].r0][hbd_pkg::LOBES_XX[i].c1]));
            dyy = dyy + box_sum(hbd_pkg::LOBES_YY[i],
                LB'(window_reg[hbd_pkg::LOBES_YY[i].r0][hbd_pkg::LOBES_YY[i].c0]),
                LB'(window_reg[hbd_pkg::LOBES_YY[i].r1][hbd_pkg::LOBES_YY[i].c1]),
                LB'(window_reg[hbd_pkg::LOBES_YY[i].r1][hbd_pkg::LOBES_YY[i].c0]),
                LB'(window_reg[hbd_pkg::LOBES_YY[i].r0][hbd_pkg::LOBES_YY[i].c1]));
        end
        for (int i = 0; i < 4; i++) begin
            dxy = dxy + box_sum(hbd_pkg::LOBES_XY[i],
                LB'(window_reg[hbd_pkg::LOBES_XY[i].r0][hbd_pkg::LOBES_XY[i].c0]),
                LB'(window_reg[hbd_pkg::LOBES_XY[i].r1][hbd_pkg::LOBES_XY[i].c1]),
                LB'(window_reg[hbd_pkg::LOBES_XY[i].r1][hbd_pkg::LOBES_XY[i].c0]),
                LB'(window_reg[hbd_pkg::LOBES_XY[i].r0][hbd_pkg::LOBES_XY[i].c1]));
        end
    end

    // stage 3: responses, low bits only
    logic          s3_valid_reg;
    logic          s3_last_reg;
    logic [PB-1:0] s3_row_reg, s3_col_reg;
    logic [DB-1:0] dxx_reg, dyy_reg;
    logic [XB-1:0] dxy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dxx_reg     <= dxx[DB-1:0];
            dyy_reg     <= dyy[DB-1:0];
            dxy_reg     <= dxy[XB-1:0];
            s3_last_reg <= s2_last_reg;
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
        end
    end

    // stage 4: products
    logic          s4_valid_reg;
    logic          s4_last_reg;
    logic [PB-1:0] s4_row_reg, s4_col_reg;
    logic [DB-1:0] pxy_reg;
    logic [DB-1:0] half_sq_reg;
    logic [2*DB-1:0] p_full;
    logic [2*XB-1:0] sq_full;

    assign p_full  = dxx_reg * dyy_reg;
    assign sq_full = dxy_reg * dxy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pxy_reg     <= p_full[DB-1:0];
            half_sq_reg <= sq_full[XB-1:1];
            s4_last_reg <= s3_last_reg;
            s4_row_reg  <= s3_row_reg;
            s4_col_reg  <= s3_col_reg;
        end
    end

    // output register
    logic [DB-1:0] det_reg;
    logic [PB-1:0] out_row_reg, out_col_reg;
    logic          out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg      <= pxy_reg - half_sq_reg;
            out_row_reg  <= s4_row_reg;
            out_col_reg  <= s4_col_reg;
            out_last_reg <= s4_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_det_value  = det_reg;
    assign m_det_stored = det_reg[hbd_pkg::STORED_BITS-1:0];
    assign m_out_row    = out_row_reg;
    assign m_out_col    = out_col_reg;
    assign m_frame_last = out_last_reg;

`ifndef ASSERT_OFF
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_slot_reg <= LAST_SLOT)
        else $error("row slot out of range");

    a_slot_zero_row: assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg == '0 |-> row_slot_reg == '0)
        else $error("row slot not aligned to row zero");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        DIMB'(col_count_reg) <= MAXC)
        else $error("column counter beyond line memory");

    a_pipe_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg && adv |=> m_valid_reg)
        else $error("result lost before output register");
`endif

endmodule
